>>> rtl/pwmm_pkg.sv
package pwmm_pkg;

    // Default width of the tick counter
    localparam int unsigned COUNTER_WIDTH_DEF = 16;

    // Result field widths and the numerator width
    localparam int unsigned OUT_W  = 16;
    localparam int unsigned DUTY_W = 7;
    localparam int unsigned NUM_W  = 16;

    // Largest value an on/period field can carry
    localparam logic [OUT_W-1:0]  OUT_MAX = 16'hFFFF;

    // Percent scale and its ceiling
    localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;

    // Reset value of the frequency numerator register
    localparam logic [NUM_W-1:0]  FREQ_NUM_RESET = 16'd8000;

endpackage

>>> rtl/pwmm_div.sv
module pwmm_div #(
    parameter int unsigned DIV_W = 23,
    parameter int unsigned DEN_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;

    logic [DEN_W:0]   trial;
    logic             q_bit;
    logic [DEN_W-1:0] rem_next;

    // Restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        q_bit = (trial >= {1'b0, divisor});
        if (q_bit) begin
            rem_next = DEN_W'(trial - {1'b0, divisor});
        end else begin
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/pwm_input_duty_frequency_meter_unit.sv
// PWM input meter. Each beat on the s_ channel is one prescaled timer tick
// with the sampled pin level and a start request. A start arms the meter;
// the next rising edge clears the tick counter, the falling edge captures
// the on-time and the following rising edge captures the period. One result
// beat then leaves on the m_ channel: on and period counts (clamped to 16
// bits, status set if clamped), duty = on*100/period in percent, frequency =
// cfg numerator / period, and status 1 if the counter saturated. A tick that
// ends no measurement leaves s_ready high. A tick that ends a measurement
// holds s_ready low until its result is loaded into the output register.
// The one shared restoring divider, with DIV_W = max(COUNTER_WIDTH+7, 16),
// produces one quotient bit per cycle and runs twice, first for the duty,
// then for the frequency. A finished result sits in the output register
// until taken, and further ticks are accepted meanwhile; only a second
// completing measurement waits for the output register to empty. The
// numerator register is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready, and resets to 8000.
module pwm_input_duty_frequency_meter_unit #(
    parameter int unsigned COUNTER_WIDTH = pwmm_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pwmm_pkg::NUM_W-1:0]  cfg_data,
    // tick input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_start_req,
    input  logic                        s_pin_level,
    // measurement result
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pwmm_pkg::OUT_W-1:0]  m_on_ticks,
    output logic [pwmm_pkg::OUT_W-1:0]  m_period_ticks,
    output logic [pwmm_pkg::DUTY_W-1:0] m_duty_percent,
    output logic [pwmm_pkg::OUT_W-1:0]  m_frequency,
    output logic                        m_status
);

    import pwmm_pkg::*;

    localparam int unsigned CW    = COUNTER_WIDTH;
    localparam int unsigned DIV_W = (CW + 7 > NUM_W) ? CW + 7 : NUM_W;
    localparam int unsigned CMP_W = (CW > OUT_W) ? CW : OUT_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ARMED,
        PH_HIGH,
        PH_LOW
    } meas_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DUTY,
        ST_FREQ,
        ST_LOAD
    } seq_state_t;

    // Measurement state
    meas_phase_t      phase_reg;
    logic             prev_level_reg;
    logic [CW-1:0]    tick_count_reg;
    logic [CW-1:0]    on_cap_reg;
    logic             sat_reg;

    // Sequencer and result staging
    seq_state_t       state_reg;
    logic [NUM_W-1:0] freq_num_reg;
    logic [CW-1:0]    res_on_reg;
    logic [CW-1:0]    res_per_reg;
    logic             res_st_reg;
    logic [DUTY_W-1:0] res_duty_reg;
    logic [OUT_W-1:0] res_freq_reg;
    logic             div_start_reg;
    logic [DIV_W-1:0] div_dividend_reg;

    // Output register
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_on_reg;
    logic [OUT_W-1:0]  m_per_reg;
    logic [DUTY_W-1:0] m_duty_reg;
    logic [OUT_W-1:0]  m_freq_reg;
    logic              m_status_reg;

    // Tick evaluation
    meas_phase_t      phase_next;
    logic [CW-1:0]    tick_count_next;
    logic [CW-1:0]    on_cap_next;
    logic             sat_next;
    logic             emit;
    logic             rising;
    logic             falling;

    // Divider
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic             per_zero;
    logic             on_big;
    logic             per_big;
    logic             tick_acc;
    logic             out_free;

    assign tick_acc = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign per_zero = (res_per_reg == '0);

    // Judge one tick: start first, then count, then edges
    always_comb begin
        rising          = s_pin_level && !prev_level_reg;
        falling         = !s_pin_level && prev_level_reg;
        phase_next      = phase_reg;
        sat_next        = sat_reg;
        tick_count_next = tick_count_reg;
        on_cap_next     = on_cap_reg;
        emit            = 1'b0;

        if (s_start_req) begin
            phase_next = PH_ARMED;
            sat_next   = 1'b0;
        end

        // Saturate instead of wrapping
        if (phase_next == PH_HIGH || phase_next == PH_LOW) begin
            if (tick_count_reg == CNT_MAX) begin
                sat_next = 1'b1;
            end else begin
                tick_count_next = tick_count_reg + CW'(1);
            end
        end

        unique case (phase_next)
            PH_ARMED: begin
                if (rising) begin
                    tick_count_next = '0;
                    phase_next      = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (falling) begin
                    on_cap_next = tick_count_next;
                    phase_next  = PH_LOW;
                end
            end
            PH_LOW: begin
                if (rising) begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    // Counts wider than the result fields clamp and flag
    assign on_big  = (CMP_W'(res_on_reg) > CMP_W'(OUT_MAX));
    assign per_big = (CMP_W'(res_per_reg) > CMP_W'(OUT_MAX));

    pwmm_div #(
        .DIV_W (DIV_W),
        .DEN_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (res_per_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            prev_level_reg <= 1'b0;
            tick_count_reg <= '0;
            on_cap_reg     <= '0;
            sat_reg        <= 1'b0;
            state_reg      <= ST_IDLE;
            freq_num_reg   <= FREQ_NUM_RESET;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;

            if (cfg_valid && cfg_ready) begin
                freq_num_reg <= cfg_data;
            end

            // Drop the result once the sink takes it
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (tick_acc) begin
                        prev_level_reg <= s_pin_level;
                        phase_reg      <= phase_next;
                        tick_count_reg <= tick_count_next;
                        on_cap_reg     <= on_cap_next;
                        sat_reg        <= sat_next;
                        if (emit) begin
                            // Latch the capture and launch the duty division
                            res_on_reg       <= on_cap_reg;
                            res_per_reg      <= tick_count_next;
                            res_st_reg       <= sat_next;
                            div_dividend_reg <= DIV_W'(on_cap_reg) * DIV_W'(DUTY_SCALE);
                            div_start_reg    <= 1'b1;
                            state_reg        <= ST_DUTY;
                        end
                    end
                end
                ST_DUTY: begin
                    if (div_done) begin
                        if (per_zero) begin
                            res_duty_reg <= '0;
                        end else if (div_quo > DIV_W'(DUTY_SCALE)) begin
                            res_duty_reg <= DUTY_SCALE;
                        end else begin
                            res_duty_reg <= div_quo[DUTY_W-1:0];
                        end
                        // Reuse the divider for the frequency
                        div_dividend_reg <= DIV_W'(freq_num_reg);
                        div_start_reg    <= 1'b1;
                        state_reg        <= ST_FREQ;
                    end
                end
                ST_FREQ: begin
                    if (div_done) begin
                        res_freq_reg <= per_zero ? '0 : div_quo[OUT_W-1:0];
                        state_reg    <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_on_reg     <= on_big ? OUT_MAX : OUT_W'(res_on_reg);
                        m_per_reg    <= per_big ? OUT_MAX : OUT_W'(res_per_reg);
                        m_duty_reg   <= res_duty_reg;
                        m_freq_reg   <= res_freq_reg;
                        m_status_reg <= res_st_reg || on_big || per_big;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_on_ticks     = m_on_reg;
    assign m_period_ticks = m_per_reg;
    assign m_duty_percent = m_duty_reg;
    assign m_frequency    = m_freq_reg;
    assign m_status       = m_status_reg;

endmodule

>>> rtl/pwmm_checker.sv
module pwmm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pwmm_pkg::OUT_W-1:0]  m_on_ticks,
    input logic [pwmm_pkg::OUT_W-1:0]  m_period_ticks,
    input logic [pwmm_pkg::DUTY_W-1:0] m_duty_percent,
    input logic [pwmm_pkg::OUT_W-1:0]  m_frequency,
    input logic                        m_status
);

    import pwmm_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_on_ticks)
            && $stable(m_period_ticks) && $stable(m_duty_percent)
            && $stable(m_frequency) && $stable(m_status))
        else $error("result beat changed while stalled");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty_percent <= DUTY_SCALE)
        else $error("duty above full scale");

    // Clean measurement: on-time ends before the period does
    a_on_lt_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_on_ticks < m_period_ticks)
        else $error("on-time not below period");

    // A result is loaded only while the tick input is held off
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result loaded while ticks were accepted");

endmodule

bind pwm_input_duty_frequency_meter_unit pwmm_checker u_pwmm_checker (.*);
